// ===== hw/rtl/frwm_pkg.sv =====
// ----------------------------------------------------------------------------
// frwm_pkg
// shared types and constants of the windowed frame rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frwm_pkg;

    // payload field widths
    localparam int DUR_W   = 24;
    localparam int TS_W    = 40;
    localparam int RATE_W  = 22;
    localparam int FRAMES_W = 6;
    localparam int SCALE_W = 16;
    localparam int DIFF_W  = 32;

    localparam int S_TDATA_W = DUR_W + TS_W;                  // 64
    localparam int M_TDATA_W = 56;                            // 50 bits used

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_MOVIE_RATE_SCALE = 1'b0;

    // arithmetic constants
    localparam int unsigned RATE_CAP_UNITS = 9999;
    localparam int unsigned US_PER_SECOND  = 1000000;
    localparam int unsigned FRAC_BITS      = 8;
    localparam logic [RATE_W-1:0] RATE_CAP = RATE_W'(RATE_CAP_UNITS << FRAC_BITS);
    localparam logic [27:0] PLAY_SCALE = 28'(US_PER_SECOND << FRAC_BITS);
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;   // latch input beat, issue ring reads
        logic update;    // write rings, update sum, slot and counters
        logic load_div;  // start both dividers
        logic finish;    // load the output register
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_hold;  // output register full and not taken
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frwm_ram.sv =====
// ----------------------------------------------------------------------------
// frwm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/frwm_div.sv =====
// ----------------------------------------------------------------------------
// frwm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frwm_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 31
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             q_bit;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        q_bit = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits DEN_W bits
            rem_next = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frwm_datapath.sv =====
// ----------------------------------------------------------------------------
// frwm_datapath
// rings, running duration sum, rate dividers and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frwm_datapath #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire frwm_pkg::cmd_t                      cmd,
    output frwm_pkg::status_t                        status,
    input  wire logic [frwm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [frwm_pkg::SCALE_W-1:0]        movie_rate_scale,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [frwm_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SLOT_W + frwm_pkg::DUR_W;
    localparam longint unsigned PLAY_NUM_MAX =
        longint'(WINDOW_DEPTH) * longint'(frwm_pkg::PLAY_SCALE);
    localparam int NUM_W  = $clog2(PLAY_NUM_MAX + 1);
    localparam int DEN_W  = (SUM_W > frwm_pkg::DIFF_W - 1) ? SUM_W : frwm_pkg::DIFF_W - 1;
    localparam int DUR_W  = frwm_pkg::DUR_W;
    localparam int TS_W   = frwm_pkg::TS_W;
    localparam int RATE_W = frwm_pkg::RATE_W;
    localparam int DIFF_W = frwm_pkg::DIFF_W;

    // input beat and window state
    logic [DUR_W-1:0]  dur_in_reg, dur_in_next;
    logic [TS_W-1:0]   ts_in_reg, ts_in_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIFF_W-1:0] diff_reg, diff_next;
    logic              first_is_new_reg, first_is_new_next;

    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] first_addr;
    logic [DUR_W-1:0]  dur_rd;
    logic [TS_W-1:0]   ts_rd;
    logic [DUR_W-1:0]  old_dur;
    logic [TS_W-1:0]   ts_first;
    logic              wrap;

    logic [NUM_W-1:0]  play_num, movie_num;
    logic [DEN_W-1:0]  play_den, movie_den;
    logic              play_busy, movie_busy;
    logic [NUM_W-1:0]  play_q, movie_q;
    logic [RATE_W-1:0] play_rate, movie_rate;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [frwm_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign wrap     = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1));
    assign slot_inc = wrap ? '0 : slot_reg + 1'b1;
    // oldest entry left once the window is full is the slot after the one written now
    assign first_addr = full_reg ? slot_inc : '0;

    frwm_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_dur_ring (
        .clk     (aclk),
        .wr_en   (cmd.update),
        .wr_addr (slot_reg),
        .wr_data (dur_in_reg),
        .rd_en   (cmd.capture),
        .rd_addr (slot_reg),
        .rd_data (dur_rd)
    );

    frwm_ram #(
        .WIDTH (TS_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ts_ring (
        .clk     (aclk),
        .wr_en   (cmd.update),
        .wr_addr (slot_reg),
        .wr_data (ts_in_reg),
        .rd_en   (cmd.capture),
        .rd_addr (first_addr),
        .rd_data (ts_rd)
    );

    always_comb begin
        dur_in_next       = dur_in_reg;
        ts_in_next        = ts_in_reg;
        first_is_new_next = first_is_new_reg;
        slot_next         = slot_reg;
        full_next         = full_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        diff_next         = diff_reg;

        // slots not yet written since reset count as a zero duration
        old_dur  = full_reg ? dur_rd : '0;
        ts_first = first_is_new_reg ? ts_in_reg : ts_rd;

        if (cmd.capture) begin
            dur_in_next       = s_tdata[DUR_W-1:0];
            ts_in_next        = s_tdata[DUR_W +: TS_W];
            first_is_new_next = !full_reg && (slot_reg == '0);
        end
        if (cmd.update) begin
            sum_next   = sum_reg - SUM_W'(old_dur) + SUM_W'(dur_in_reg);
            slot_next  = slot_inc;
            full_next  = full_reg | wrap;
            count_next = (full_reg | wrap) ? CNT_W'(WINDOW_DEPTH) : CNT_W'(slot_inc);
            diff_next  = ts_in_reg[DIFF_W-1:0] - ts_first[DIFF_W-1:0];
        end
    end

    always_comb begin
        play_num  = NUM_W'(count_reg) * NUM_W'(frwm_pkg::PLAY_SCALE);
        movie_num = (NUM_W'(count_reg - 1'b1) * NUM_W'(movie_rate_scale))
                    << frwm_pkg::FRAC_BITS;
        play_den  = DEN_W'(sum_reg);
        movie_den = DEN_W'(diff_reg[DIFF_W-2:0]);
    end

    frwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_play_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load_div),
        .num      (play_num),
        .den      (play_den),
        .busy     (play_busy),
        .quotient (play_q)
    );

    frwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_movie_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load_div),
        .num      (movie_num),
        .den      (movie_den),
        .busy     (movie_busy),
        .quotient (movie_q)
    );

    always_comb begin
        if (sum_reg == '0) begin
            play_rate = frwm_pkg::RATE_CAP;
        end else if (play_q > NUM_W'(frwm_pkg::RATE_CAP)) begin
            play_rate = frwm_pkg::RATE_CAP;
        end else begin
            play_rate = play_q[RATE_W-1:0];
        end

        // negative timestamp step clamps to zero
        if (diff_reg == '0) begin
            movie_rate = frwm_pkg::RATE_CAP;
        end else if (diff_reg[DIFF_W-1]) begin
            movie_rate = '0;
        end else if (movie_q > NUM_W'(frwm_pkg::RATE_CAP)) begin
            movie_rate = frwm_pkg::RATE_CAP;
        end else begin
            movie_rate = movie_q[RATE_W-1:0];
        end

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, frwm_pkg::FRAMES_W'(count_reg), movie_rate, play_rate};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            slot_reg     <= slot_next;
            full_reg     <= full_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dur_in_reg       <= dur_in_next;
        ts_in_reg        <= ts_in_next;
        first_is_new_reg <= first_is_new_next;
        count_reg        <= count_next;
        diff_reg         <= diff_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign status.div_busy = play_busy | movie_busy;
    assign status.out_hold = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frwm_ctrl
// sequencer for one frame record: fetch, update, divide, deliver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frwm_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire frwm_pkg::status_t  status,
    output frwm_pkg::cmd_t          cmd
);

    frwm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frwm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            frwm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = frwm_pkg::ST_FETCH;
                end
            end
            frwm_pkg::ST_FETCH: begin
                cmd.update = 1'b1;
                state_next = frwm_pkg::ST_LOAD;
            end
            frwm_pkg::ST_LOAD: begin
                cmd.load_div = 1'b1;
                state_next   = frwm_pkg::ST_DIV;
            end
            frwm_pkg::ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = frwm_pkg::ST_DONE;
                end
            end
            frwm_pkg::ST_DONE: begin
                // wait for the previous result to leave the output register
                if (!status.out_hold) begin
                    cmd.finish = 1'b1;
                    state_next = frwm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = frwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_frame_rate_meter_core.sv =====
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter_core
// frame rate meter over a sliding window of frame records
// ----------------------------------------------------------------------------
// Each s_ beat is one frame record: playback duration in microseconds and a
// decode timestamp. It is written into a ring of WINDOW_DEPTH slots and gives
// one m_ beat with the play rate (frames per second from the duration sum),
// the movie rate (from the oldest and newest timestamps, scaled by the
// movie_rate_scale register) and the number of records in the window. Both
// rates carry 8 fractional bits and saturate at 9999.
// An accepted input beat updates the rings and the sum, then starts the two
// restoring dividers, which run side by side on NUM_W bit numerators (33 bits
// at the default depth); once both are done the result goes to the output
// register and m_tvalid rises. A new record is taken once the previous one is
// handed to the output register.
// The output register holds a finished result while m_tready is low; the
// next record is accepted meanwhile and waits for the register to empty.
// Reset empties the window and the duration sum and sets the scale to 3000;
// no clearing pass is needed. The user must write the scale register over the
// APB port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_frame_rate_meter_core #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input record
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [23:0] frame_duration_us, [63:24] decode_timestamp
    input  wire logic [frwm_pkg::S_TDATA_W-1:0]      s_tdata,
    // result
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [21:0] play_rate, [43:22] movie_rate, [49:44] frames_in_window
    output logic      [frwm_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [frwm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [frwm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [frwm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    frwm_pkg::cmd_t    cmd;
    frwm_pkg::status_t status;

    logic [frwm_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                         reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == frwm_pkg::REG_MOVIE_RATE_SCALE);

    always_comb begin
        scale_next = scale_reg;
        if (psel && penable && pwrite && reg_hit) begin
            scale_next = pwdata[frwm_pkg::SCALE_W-1:0];
        end
        prdata = reg_hit ? frwm_pkg::APB_DATA_W'(scale_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= frwm_pkg::SCALE_RESET;
        end else begin
            scale_reg <= scale_next;
        end
    end

    frwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frwm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_tdata          (s_tdata),
        .movie_rate_scale (scale_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/frwm_checker.sv =====
// ----------------------------------------------------------------------------
// frwm_checker
// port level checks of the frame rate meter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frwm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [frwm_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // both rates saturate at the cap
    a_rate_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:0] <= frwm_pkg::RATE_CAP)
                  && (m_tdata[43:22] <= frwm_pkg::RATE_CAP))
        else $error("rate above saturation value");

    // one record in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second record accepted while busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind windowed_frame_rate_meter_core frwm_checker u_frwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
